// ===== hw/rtl/kfwrl_pkg.sv =====
// shared types and constants for the keyed fixed-window rate limiter
`timescale 1ns / 1ps

package kfwrl_pkg;

  localparam int unsigned KEY_W         = 64;
  localparam int unsigned TIME_W        = 48;
  localparam int unsigned COUNT_W       = 31;
  // entries with a window start over this many windows back get freed by a sweep
  localparam int unsigned STALE_WINDOWS = 2;

  typedef struct packed {
    logic [KEY_W-1:0]  event_key;
    logic [TIME_W-1:0] time_ms;
  } kfwrl_in_t;

  typedef struct packed {
    logic allowed;
    logic untracked;
  } kfwrl_out_t;

  // one table row as kept in the entry ram
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [TIME_W-1:0]  window_ms;
    logic [TIME_W-1:0]  window_idx;
    logic [COUNT_W-1:0] count;
  } kfwrl_row_t;

endpackage

// ===== hw/rtl/kfwrl_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module kfwrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/keyed_fixed_window_rate_limiter.sv =====
// top level of the keyed fixed-window rate limiter
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------
//   input    | in_valid / in_stall      | in_data   (event_key, time_ms)
//   output   | out_valid / out_stall    | out_data  (allowed, untracked)
//   config   | cfg_wr_en                | cfg_wr_data (events_per_second)
//
// after reset a clearing pass writes every table row invalid, with
// in_stall high throughout; config writes are taken at any time.
// with a zero limit an item goes from S_IDLE straight to S_RESULT, where the result loads.
// otherwise it passes S_SWEEP_CHK, S_SWEEP when a sweep is due, S_LOOKUP and S_DECIDE;
// both ram walks read one row per cycle, and a new item is taken only back in S_IDLE.
// a result held by out_stall blocks only the end of the next item.
`timescale 1ns / 1ps

module keyed_fixed_window_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES     = 16,
  parameter int unsigned WINDOW_MS         = 1000,
  parameter int unsigned SWEEP_INTERVAL_MS = 60000
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  kfwrl_pkg::kfwrl_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output kfwrl_pkg::kfwrl_out_t  out_data,
  input  logic                   cfg_wr_en,
  input  logic [kfwrl_pkg::COUNT_W-1:0] cfg_wr_data
);

  import kfwrl_pkg::*;

  localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ROW_W = $bits(kfwrl_row_t);

  // time_ms / WINDOW_MS as (time_ms * RECIP) >> RS, exact for every 48-bit time
  localparam int unsigned RL    = $clog2(WINDOW_MS);
  localparam int unsigned RS    = TIME_W + RL;
  localparam int unsigned MW    = TIME_W + 1;
  localparam int unsigned NLW   = TIME_W / 2;
  localparam int unsigned MLW   = MW - NLW;
  localparam int unsigned PW    = NLW + MLW;
  localparam int unsigned ACC_W = RS + TIME_W + 1;

  localparam logic [RS:0]       RECIP_WIDE = (((RS + 1)'(1) << RS) +
                                              (RS + 1)'(WINDOW_MS - 1)) /
                                             (RS + 1)'(WINDOW_MS);
  localparam logic [MW-1:0]     RECIP      = MW'(RECIP_WIDE);

  localparam logic [CW-1:0]     ENTRY_CNT  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0]     LAST_IDX   = CW'(TABLE_ENTRIES - 1);
  localparam logic [TIME_W:0]   STALE_SPAN = (TIME_W + 1)'(STALE_WINDOWS * WINDOW_MS);
  localparam logic [TIME_W-1:0] SWEEP_SPAN = TIME_W'(SWEEP_INTERVAL_MS);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_SWEEP_CHK = 7'b0000100,
    S_SWEEP     = 7'b0001000,
    S_LOOKUP    = 7'b0010000,
    S_DECIDE    = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0] limit;
  logic [TIME_W-1:0]  last_sweep;
  kfwrl_in_t          ev;
  kfwrl_out_t         res;

  logic [CW-1:0] ptr;
  logic          pend;
  logic [AW-1:0] pend_idx;

  logic          hit_found;
  logic [AW-1:0] hit_idx;
  kfwrl_row_t    hit_row;
  logic          spare_found;
  logic [AW-1:0] spare_idx;

  // shared multiplier, one partial product a cycle, summed into mul_acc
  logic [TIME_W-1:0] mul_num;
  logic [ACC_W-1:0]  mul_acc;
  logic [1:0]        mul_step;
  logic              mul_run;
  logic [NLW-1:0]    mul_a;
  logic [MLW-1:0]    mul_b;
  logic [PW-1:0]     mul_prod;
  logic [ACC_W-1:0]  mul_term;
  logic [TIME_W-1:0] div_quot;
  logic              div_done;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  kfwrl_row_t       ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  kfwrl_row_t       rd_row;

  logic       issue;
  logic       stale;
  logic       sweep_due;
  logic       key_match;
  kfwrl_row_t sel_row;
  logic       tracked;
  logic       new_window;
  logic       under_limit;
  logic [AW-1:0] dec_idx;

  kfwrl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_row    = kfwrl_row_t'(ram_rdata);
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    case (mul_step)
      2'd0: begin
        mul_a    = mul_num[NLW-1:0];
        mul_b    = RECIP[MLW-1:0];
      end
      2'd1: begin
        mul_a    = mul_num[NLW-1:0];
        mul_b    = MLW'(RECIP[MW-1:MLW]);
      end
      2'd2: begin
        mul_a    = mul_num[TIME_W-1:NLW];
        mul_b    = RECIP[MLW-1:0];
      end
      default: begin
        mul_a    = mul_num[TIME_W-1:NLW];
        mul_b    = MLW'(RECIP[MW-1:MLW]);
      end
    endcase
  end

  assign mul_prod = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    case (mul_step)
      2'd0:    mul_term = ACC_W'(mul_prod);
      2'd1:    mul_term = ACC_W'(mul_prod) << MLW;
      2'd2:    mul_term = ACC_W'(mul_prod) << NLW;
      default: mul_term = ACC_W'(mul_prod) << (NLW + MLW);
    endcase
  end

  assign div_quot  = mul_acc[RS +: TIME_W];
  assign div_done  = !mul_run;

  assign stale     = ({1'b0, rd_row.window_ms} + STALE_SPAN) < {1'b0, ev.time_ms};
  assign sweep_due = (ev.time_ms >= last_sweep) &&
                     ((ev.time_ms - last_sweep) >= SWEEP_SPAN);
  assign key_match = rd_row.valid && (rd_row.key == ev.event_key);

  always_comb begin
    if (hit_found) begin
      sel_row = hit_row;
      dec_idx = hit_idx;
    end else begin
      sel_row            = '0;
      sel_row.valid      = 1'b1;
      sel_row.key        = ev.event_key;
      dec_idx            = spare_idx;
    end
  end

  assign tracked     = hit_found || spare_found;
  assign new_window  = (div_quot > sel_row.window_idx);
  assign under_limit = (sel_row.count < limit);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = pend_idx;
    ram_wdata  = '0;
    ram_raddr  = ptr[AW-1:0];
    issue      = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
        if (ptr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = (limit == '0) ? S_RESULT : S_SWEEP_CHK;
        end
      end
      S_SWEEP_CHK: begin
        state_next = sweep_due ? S_SWEEP : S_LOOKUP;
      end
      S_SWEEP: begin
        issue = (ptr != ENTRY_CNT);
        // read of the next row overlaps the write-back of the previous one
        if (pend && rd_row.valid && stale) begin
          ram_we          = 1'b1;
          ram_wdata       = rd_row;
          ram_wdata.valid = 1'b0;
        end
        if (!issue && !pend) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        issue = (ptr != ENTRY_CNT);
        if (!issue && !pend && div_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ram_waddr = dec_idx;
        if (tracked && new_window) begin
          ram_we               = 1'b1;
          ram_wdata.valid      = 1'b1;
          ram_wdata.key        = ev.event_key;
          ram_wdata.window_ms  = ev.time_ms;
          ram_wdata.window_idx = div_quot;
          ram_wdata.count      = COUNT_W'(1);
        end else if (tracked && under_limit) begin
          ram_we          = 1'b1;
          ram_wdata       = sel_row;
          ram_wdata.count = sel_row.count + COUNT_W'(1);
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      pend       <= 1'b0;
      limit      <= '0;
      last_sweep <= '0;
      out_valid  <= 1'b0;
      mul_run    <= 1'b0;
      mul_step   <= '0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end

      if (state == S_RESULT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == S_IDLE && in_valid) begin
        mul_num  <= in_data.time_ms;
        mul_acc  <= '0;
        mul_step <= '0;
        mul_run  <= 1'b1;
      end else if (mul_run) begin
        mul_acc  <= mul_acc + mul_term;
        mul_step <= mul_step + 2'd1;
        mul_run  <= (mul_step != 2'd3);
      end

      case (state)
        S_CLEAR: begin
          ptr <= (ptr == LAST_IDX) ? '0 : ptr + CW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            ev            <= in_data;
            hit_found     <= 1'b0;
            spare_found   <= 1'b0;
            ptr           <= '0;
            pend          <= 1'b0;
            res.allowed   <= 1'b1;
            res.untracked <= 1'b0;
          end
        end
        S_SWEEP_CHK: begin
          if (sweep_due) begin
            last_sweep <= ev.time_ms;
          end
        end
        S_SWEEP: begin
          pend     <= issue;
          pend_idx <= ptr[AW-1:0];
          if (issue) begin
            ptr <= ptr + CW'(1);
          end else if (!pend) begin
            ptr <= '0;
          end
        end
        S_LOOKUP: begin
          pend     <= issue;
          pend_idx <= ptr[AW-1:0];
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (pend) begin
            if (key_match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= pend_idx;
              hit_row   <= rd_row;
            end
            if (!rd_row.valid && !spare_found) begin
              spare_found <= 1'b1;
              spare_idx   <= pend_idx;
            end
          end
        end
        S_DECIDE: begin
          res.allowed   <= !tracked || new_window || under_limit;
          res.untracked <= !tracked;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/kfwrl_checker.sv =====
// port-level checks for the rate limiter, bound to the top level
`timescale 1ns / 1ps

module kfwrl_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input kfwrl_pkg::kfwrl_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // an untracked event is always let through
  a_untracked_allowed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.untracked || out_data.allowed))
    else $error("untracked event was blocked");

  // one item at a time: busy right after a transfer in
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // the clearing pass keeps the input closed and the output empty after reset
  a_reset_closed: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block open or result shown right after reset");

endmodule

bind keyed_fixed_window_rate_limiter kfwrl_checker u_kfwrl_checker (.*);
